// File: rtl/set_assoc_cache_lru_assert.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_assert.svh
// Assertion macros used by the cache top level.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the cache front end, back end and top level.
// ----------------------------------------------------------------------------
package sac_pkg;

    // Status of the request queue between front and back end.
    typedef struct packed {
        logic empty;
        logic full;
    } sac_qstat_t;

    localparam logic [7:0] FILL_RESET = 8'h42;
    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;

endpackage

// File: rtl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// Splits each accepted access into tag, set and offset and queues it.
// ----------------------------------------------------------------------------
module sac_front #(
    parameter int SETS       = 128,
    parameter int LINE_BYTES = 32,
    parameter int ADDR_BITS  = 32,
    localparam int OffW   = $clog2(LINE_BYTES),
    localparam int SetIW  = $clog2(SETS),
    localparam int SetW   = (SetIW == 0) ? 1 : SetIW,
    localparam int EaBits = (ADDR_BITS < 32) ? ADDR_BITS : 32,
    localparam int TagW   = (EaBits - OffW - SetIW < 1) ? 1 : (EaBits - OffW - SetIW)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  mode,
    input  logic [31:0]           address,
    input  logic [7:0]            write_data,
    input  logic                  pop,
    output sac_pkg::sac_qstat_t   q_status,
    output logic                  head_mode,
    output logic [TagW-1:0]       head_tag,
    output logic [SetW-1:0]       head_set,
    output logic [OffW-1:0]       head_off,
    output logic [7:0]            head_wdata
);

    localparam logic [31:0] AMask =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [31:0] SetMask = 32'(SETS - 1);

    logic [31:0]     addr_m;
    logic [TagW-1:0] in_tag;
    logic [SetW-1:0] in_set;
    logic [OffW-1:0] in_off;

    logic            q_mode  [2];
    logic [TagW-1:0] q_tag   [2];
    logic [SetW-1:0] q_set   [2];
    logic [OffW-1:0] q_off   [2];
    logic [7:0]      q_wdata [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign addr_m = address & AMask;
    assign in_off = OffW'(addr_m);
    assign in_set = SetW'((addr_m >> OffW) & SetMask);
    assign in_tag = TagW'(addr_m >> (OffW + SetIW));

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mode[wr_ptr_reg]  <= mode;
            q_tag[wr_ptr_reg]   <= in_tag;
            q_set[wr_ptr_reg]   <= in_set;
            q_off[wr_ptr_reg]   <= in_off;
            q_wdata[wr_ptr_reg] <= write_data;
        end
    end

    assign q_status.empty = (count_reg == 2'd0);
    assign q_status.full  = (count_reg == 2'd2);
    assign head_mode  = q_mode[rd_ptr_reg];
    assign head_tag   = q_tag[rd_ptr_reg];
    assign head_set   = q_set[rd_ptr_reg];
    assign head_off   = q_off[rd_ptr_reg];
    assign head_wdata = q_wdata[rd_ptr_reg];

endmodule

// File: rtl/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back
// Looks up the set, picks hit or victim way, updates ranks, tags and data.
// ----------------------------------------------------------------------------
module sac_back #(
    parameter int WAYS       = 8,
    parameter int SETS       = 128,
    parameter int LINE_BYTES = 32,
    parameter int ADDR_BITS  = 32,
    localparam int OffW   = $clog2(LINE_BYTES),
    localparam int SetIW  = $clog2(SETS),
    localparam int SetW   = (SetIW == 0) ? 1 : SetIW,
    localparam int EaBits = (ADDR_BITS < 32) ? ADDR_BITS : 32,
    localparam int TagW   = (EaBits - OffW - SetIW < 1) ? 1 : (EaBits - OffW - SetIW)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sac_pkg::sac_qstat_t q_status,
    input  logic                head_mode,
    input  logic [TagW-1:0]     head_tag,
    input  logic [SetW-1:0]     head_set,
    input  logic [OffW-1:0]     head_off,
    input  logic [7:0]          head_wdata,
    input  logic [7:0]          fill_value,
    output logic                pop,
    output logic                clearing,
    output logic                done,
    output logic                hit,
    output logic [7:0]          read_data,
    output logic                done_kind
);

    localparam int RankW  = $clog2(WAYS + 1);
    localparam int WayW   = $clog2(WAYS);
    localparam int LineW  = $clog2(SETS * WAYS);
    localparam int EntW   = 1 + RankW + TagW;
    localparam int RowW   = WAYS * EntW;
    localparam int DataW  = LINE_BYTES * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;

    logic [RowW-1:0]  meta_mem [SETS];
    logic [DataW-1:0] data_mem [SETS * WAYS];

    logic [1:0]      state_reg, state_next;
    logic            clr_reg;
    logic [SetW-1:0] clr_cnt_reg;
    logic            done_reg, done_next;

    logic            cur_mode_reg;
    logic [TagW-1:0] cur_tag_reg;
    logic [SetW-1:0] cur_set_reg;
    logic [OffW-1:0] cur_off_reg;
    logic [7:0]      cur_wdata_reg;
    logic [RowW-1:0]  meta_q_reg;
    logic [DataW-1:0] data_q_reg;
    logic            hit_reg, hit_next;
    logic [7:0]      rdata_reg, rdata_next;
    logic            kind_reg, kind_next;

    logic [WAYS-1:0]  way_valid;
    logic [RankW-1:0] way_rank [WAYS];
    logic [TagW-1:0]  way_tag  [WAYS];
    logic [WAYS-1:0]  match;
    logic             hit_any;
    logic [WayW-1:0]  hit_way, empty_way, lru_way, way_sel;
    logic             have_empty;
    logic [RankW-1:0] old_rank, r;
    logic [RowW-1:0]  new_row;
    logic [LineW-1:0] line_c;
    logic             data_we;
    logic [LINE_BYTES-1:0] data_be;
    logic [DataW-1:0] data_wrow;

    assign pop = (state_reg == ST_IDLE) && !clr_reg && !q_status.empty;

    always_comb
    begin
        hit_way    = '0;
        empty_way  = '0;
        lru_way    = '0;
        have_empty = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            way_valid[w] = meta_q_reg[w * EntW + EntW - 1];
            way_rank[w]  = meta_q_reg[w * EntW + TagW +: RankW];
            way_tag[w]   = meta_q_reg[w * EntW +: TagW];
            match[w]     = way_valid[w] && (way_tag[w] == cur_tag_reg);
            if (match[w])
                hit_way = WayW'(w);
            if (way_rank[w] == '0)
            begin
                empty_way  = WayW'(w);
                have_empty = 1'b1;
            end
            if (way_rank[w] == RankW'(WAYS))
                lru_way = WayW'(w);
        end
        hit_any  = |match;
        way_sel  = hit_any ? hit_way : (have_empty ? empty_way : lru_way);
        old_rank = way_rank[way_sel];

        // Accessed way becomes rank 1; younger ways age by one.
        for (int w = 0; w < WAYS; w++)
        begin
            r = way_rank[w];
            if (WayW'(w) == way_sel)
                new_row[w * EntW +: EntW] = {1'b1, RankW'(1), cur_tag_reg};
            else if (r != '0 && (old_rank == '0 || r < old_rank))
                new_row[w * EntW +: EntW] = {way_valid[w], RankW'(r + RankW'(1)), way_tag[w]};
            else
                new_row[w * EntW +: EntW] = {way_valid[w], r, way_tag[w]};
        end

        line_c  = LineW'(cur_set_reg) * LineW'(WAYS) + LineW'(way_sel);
        data_we = (state_reg == ST_EVAL) && (!hit_any || cur_mode_reg == sac_pkg::MODE_WRITE);
        for (int b = 0; b < LINE_BYTES; b++)
        begin
            data_be[b] = !hit_any || (OffW'(b) == cur_off_reg);
            data_wrow[b * 8 +: 8] =
                (cur_mode_reg == sac_pkg::MODE_WRITE && OffW'(b) == cur_off_reg)
                ? cur_wdata_reg : fill_value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        rdata_next = rdata_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                hit_next  = hit_any;
                kind_next = cur_mode_reg;
                if (hit_any && cur_mode_reg == sac_pkg::MODE_READ)
                    state_next = ST_RD;
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    rdata_next = (cur_mode_reg == sac_pkg::MODE_READ) ? fill_value : 8'd0;
                end
            end
            ST_RD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                rdata_next = data_q_reg[cur_off_reg * 8 +: 8];
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SetW'(1);
                if (clr_cnt_reg == SetW'(SETS - 1))
                    clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        rdata_reg <= rdata_next;
        kind_reg  <= kind_next;
        if (pop)
        begin
            cur_mode_reg  <= head_mode;
            cur_tag_reg   <= head_tag;
            cur_set_reg   <= head_set;
            cur_off_reg   <= head_off;
            cur_wdata_reg <= head_wdata;
        end
    end

    // Tag, valid and rank memory: one row per set.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
            meta_mem[clr_cnt_reg] <= '0;
        else if (state_reg == ST_EVAL)
            meta_mem[cur_set_reg] <= new_row;
        if (pop)
            meta_q_reg <= meta_mem[head_set];
    end

    // Data memory: one row per line, byte write enables.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            for (int b = 0; b < LINE_BYTES; b++)
            begin
                if (data_be[b])
                    data_mem[line_c][b * 8 +: 8] <= data_wrow[b * 8 +: 8];
            end
        end
        data_q_reg <= data_mem[line_c];
    end

    assign clearing  = clr_reg;
    assign done      = done_reg;
    assign hit       = hit_reg;
    assign read_data = rdata_reg;
    assign done_kind = kind_reg;

endmodule

// File: rtl/set_assoc_cache_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru
// Set-associative byte cache with write-allocate and true LRU replacement.
// ----------------------------------------------------------------------------
// An access word is taken when start is high and busy is low. Its result word
// appears on done, hit, read_data and done_kind for exactly one cycle and
// must be taken then, since the receiver cannot stall the cache. Each access
// passes through the queue, the back end's tag memory read, the tag compare
// and rank update, and for read hits the data memory read, before its result
// is registered. The back end works on one access at a time and pops the
// next only once it is back in its idle state. A two-entry queue between the
// address-splitting front end and the back end lets up to two more accesses
// be taken while one is being worked on. After reset the tag memory is
// cleared one set per cycle, with busy held high; the fill value may be
// written during that time. A miss refills the whole victim line with
// fill_value in one write of the line-wide data memory, a write miss putting
// its byte of write_data in place of fill_value in that same write.
module set_assoc_cache_lru #(
    parameter int WAYS       = 8,
    parameter int SETS       = 128,
    parameter int LINE_BYTES = 32,
    parameter int ADDR_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] address,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic        hit,
    output logic [7:0]  read_data,
    output logic        done_kind,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    localparam int OffW   = $clog2(LINE_BYTES);
    localparam int SetIW  = $clog2(SETS);
    localparam int SetW   = (SetIW == 0) ? 1 : SetIW;
    localparam int EaBits = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TagW   = (EaBits - OffW - SetIW < 1) ? 1 : (EaBits - OffW - SetIW);

    sac_pkg::sac_qstat_t q_status;
    logic            push, pop, clearing;
    logic            head_mode;
    logic [TagW-1:0] head_tag;
    logic [SetW-1:0] head_set;
    logic [OffW-1:0] head_off;
    logic [7:0]      head_wdata;
    logic [7:0]      fill_value_reg;
    logic [1:0]      pend_reg;

    // The user must write the fill value register only while the cache is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_value_reg <= sac_pkg::FILL_RESET;
        else if (cfg_we)
            fill_value_reg <= cfg_wdata;
    end

    assign busy = q_status.full || clearing;
    assign push = start && !busy;

    sac_front #(
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .address    (address),
        .write_data (write_data),
        .pop        (pop),
        .q_status   (q_status),
        .head_mode  (head_mode),
        .head_tag   (head_tag),
        .head_set   (head_set),
        .head_off   (head_off),
        .head_wdata (head_wdata)
    );

    sac_back #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_mode  (head_mode),
        .head_tag   (head_tag),
        .head_set   (head_set),
        .head_off   (head_off),
        .head_wdata (head_wdata),
        .fill_value (fill_value_reg),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .hit        (hit),
        .read_data  (read_data),
        .done_kind  (done_kind)
    );

    // Accesses taken but not yet answered: the queue plus the one in work.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_reg + 2'(push) - 2'(done);
    end

    `include "set_assoc_cache_lru_assert.svh"

    `SAC_ASSERT_IMPL(a_done_has_pending, clk, rst_n, done, pend_reg != 2'd0)
    `SAC_ASSERT_IMPL(a_write_reads_zero, clk, rst_n, done && done_kind, read_data == 8'd0)
    `SAC_ASSERT_IMPL(a_miss_reads_fill, clk, rst_n, done && !done_kind && !hit, read_data == fill_value_reg)
    `SAC_ASSERT_NEXT(a_done_spaced, clk, rst_n, done, !done)

endmodule
